// ===== sv/rsc_pkg.sv =====
package rsc_pkg;

  // value and digit store sizes
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;

  localparam int BASE_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int OUT_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam int PROD_W  = VALUE_WIDTH + BASE_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int BIT_W   = $clog2(VALUE_WIDTH);
  localparam int PC_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = CFG_IDX_W'(1);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE    = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_UP_A    = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] CHAR_UP_Z    = CHAR_W'(90);
  localparam logic [CHAR_W-1:0] CHAR_LO_A    = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CHAR_LO_Z    = CHAR_W'(122);
  localparam logic [CHAR_W-1:0] UP_OFFSET    = CHAR_W'(55);
  localparam logic [CHAR_W-1:0] LO_OFFSET    = CHAR_W'(87);

  // sequencer step addresses
  localparam logic [PC_W-1:0] STEP_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_MUL   = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_ADD   = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_INIT  = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_DIV   = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_STORE = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_READ  = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_EMIT  = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_CLEAR = PC_W'(8);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_MUL,
    OP_ADD,
    OP_INIT,
    OP_DIV,
    OP_STORE,
    OP_EMIT,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_DIV_BUSY,
    C_MORE_DIG,
    C_OUT_BUSY,
    C_MORE_OUT
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic              hit;
    logic [BASE_W-1:0] value;
  } digit_t;

  // control store
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      STEP_IDLE:  w = '{op: OP_TAKE,  cond: C_DISPATCH, target: STEP_IDLE};
      STEP_MUL:   w = '{op: OP_MUL,   cond: C_NEXT,     target: STEP_IDLE};
      STEP_ADD:   w = '{op: OP_ADD,   cond: C_ALWAYS,   target: STEP_IDLE};
      STEP_INIT:  w = '{op: OP_INIT,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_DIV:   w = '{op: OP_DIV,   cond: C_DIV_BUSY, target: STEP_DIV};
      STEP_STORE: w = '{op: OP_STORE, cond: C_MORE_DIG, target: STEP_DIV};
      STEP_READ:  w = '{op: OP_NOP,   cond: C_OUT_BUSY, target: STEP_READ};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_MORE_OUT, target: STEP_READ};
      STEP_CLEAR: w = '{op: OP_CLEAR, cond: C_ALWAYS,   target: STEP_IDLE};
      default:    w = '{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic digit_t decode_char(input logic [CHAR_W-1:0] c);
    digit_t d;
    logic [CHAR_W-1:0] t;
    d.hit = 1'b1;
    t     = '0;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      t = c - CHAR_ZERO;
    end else if (c inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
      t = c - UP_OFFSET;
    end else if (c inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
      t = c - LO_OFFSET;
    end else begin
      d.hit = 1'b0;
    end
    d.value = t[BASE_W-1:0];
    return d;
  endfunction

  function automatic logic [OUT_W-1:0] digit_to_char(input logic [BASE_W-1:0] dv);
    logic [OUT_W-1:0] r;
    if (dv <= BASE_W'(9)) begin
      r = OUT_W'(CHAR_ZERO) + OUT_W'(dv);
    end else begin
      r = OUT_W'(UP_OFFSET) + OUT_W'(dv);
    end
    return r;
  endfunction

endpackage

// ===== sv/rsc_ram.sv =====
module rsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/radix_string_converter_unit.sv =====
// radix string converter: takes a number typed as ascii text, one character per
// request, and gives it back written in another radix, one ascii digit per
// request, most significant first, with last_digit_o on the final digit and
// overflowed_o set on every digit when the 32-bit accumulator wrapped. digit
// characters 0-9, A-Z, a-z count 0-35 (not checked against the base), other
// characters are dropped, a newline ends the number; a lone newline gives "0".
// bases are saturated to 2..36 when used. steps, set by a small microcoded
// sequencer: a digit character runs accept, multiply and add, any other
// non-newline character only accept. a newline runs accept and setup, then for
// each output digit one restoring divide bit per cycle and a store write, then
// for each emitted digit a digit store read and an output register load (the
// read waits while the output is stalled), then a final clear.
// input is stalled for the whole conversion; the last digit may still sit in
// the output register while the next number is being typed.
module radix_string_converter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // character requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rsc_pkg::CHAR_W-1:0]     char_code_i,
  // digit requests
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rsc_pkg::OUT_W-1:0]      digit_char_o,
  output logic                           last_digit_o,
  output logic                           overflowed_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rsc_pkg::BASE_W-1:0]     cfg_data_i
);

  import rsc_pkg::*;

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucw_t            uw;

  // base registers
  logic [BASE_W-1:0] sb_q, tb_q;
  logic [BASE_W-1:0] sb_c, tb_c;

  // accumulate datapath
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [BASE_W-1:0]      dig_q, dig_d;
  logic [SUM_W-1:0]       sum;

  // divide datapath
  logic [VALUE_WIDTH-1:0] work_q, work_d;
  logic [BASE_W-1:0]      rem_q, rem_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [BASE_W:0]        trial;
  logic [BASE_W:0]        trial_sub;
  logic                   trial_ge;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ovf_q, out_ovf_d;

  // digit store
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [BASE_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]     cnt_dec;

  digit_t               in_dig;
  logic                 in_acc;
  logic                 out_busy;
  logic                 more_dig;

  assign uw     = ucode(pc_q);
  assign sb_c   = clamp_base(sb_q);
  assign tb_c   = clamp_base(tb_q);
  assign in_dig = decode_char(char_code_i);

  assign in_stall_o  = (uw.op != OP_TAKE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_busy = out_valid_q && out_stall_i;
  assign more_dig = (work_q != '0) && (cnt_q != CNT_W'(MAX_DIGITS - 1));

  // restoring divide, one quotient bit per cycle shifted into work_q
  assign trial     = {rem_q, work_q[VALUE_WIDTH-1]};
  assign trial_ge  = (trial >= {1'b0, tb_c});
  assign trial_sub = trial - {1'b0, tb_c};

  assign sum = {1'b0, prod_q} + SUM_W'(dig_q);

  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign ram_we    = (uw.op == OP_STORE);
  assign ram_waddr = cnt_q[ADDR_W-1:0];
  assign ram_raddr = cnt_dec[ADDR_W-1:0];

  rsc_ram #(
    .WIDTH (BASE_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rem_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next step
  always_comb begin
    pc_d = pc_q + PC_W'(1);
    case (uw.cond)
      C_NEXT:     pc_d = pc_q + PC_W'(1);
      C_ALWAYS:   pc_d = uw.target;
      C_DISPATCH: begin
        if (!in_acc) begin
          pc_d = STEP_IDLE;
        end else if (char_code_i == CHAR_NEWLINE) begin
          pc_d = STEP_INIT;
        end else if (in_dig.hit) begin
          pc_d = STEP_MUL;
        end else begin
          pc_d = STEP_IDLE;
        end
      end
      C_DIV_BUSY: if (bit_q != '0) pc_d = uw.target;
      C_MORE_DIG: if (more_dig) pc_d = uw.target;
      C_OUT_BUSY: if (out_busy) pc_d = uw.target;
      C_MORE_OUT: if (cnt_q != CNT_W'(1)) pc_d = uw.target;
      default:    pc_d = STEP_IDLE;
    endcase
  end

  // datapath actions
  always_comb begin
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    prod_d      = prod_q;
    dig_d       = dig_q;
    work_d      = work_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    out_valid_d = out_busy;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    case (uw.op)
      OP_TAKE: begin
        if (in_acc) begin
          dig_d = in_dig.value;
        end
      end
      OP_MUL: prod_d = PROD_W'(acc_q) * PROD_W'(sb_c);
      OP_ADD: begin
        acc_d = sum[VALUE_WIDTH-1:0];
        if (|sum[SUM_W-1:VALUE_WIDTH]) begin
          ovf_d = 1'b1;
        end
      end
      OP_INIT: begin
        work_d = acc_q;
        rem_d  = '0;
        bit_d  = BIT_W'(VALUE_WIDTH - 1);
        cnt_d  = '0;
      end
      OP_DIV: begin
        work_d = {work_q[VALUE_WIDTH-2:0], trial_ge};
        rem_d  = trial_ge ? trial_sub[BASE_W-1:0] : trial[BASE_W-1:0];
        bit_d  = bit_q - BIT_W'(1);
      end
      OP_STORE: begin
        // remainder goes to the store this cycle, then restart for the next digit
        cnt_d = cnt_q + CNT_W'(1);
        rem_d = '0;
        bit_d = BIT_W'(VALUE_WIDTH - 1);
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_char_d  = digit_to_char(ram_rdata);
        out_last_d  = (cnt_q == CNT_W'(1));
        out_ovf_d   = ovf_q;
        cnt_d       = cnt_dec;
      end
      OP_CLEAR: begin
        acc_d = '0;
        ovf_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      sb_q        <= BASE_RESET;
      tb_q        <= BASE_RESET;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SOURCE_BASE: sb_q <= cfg_data_i;
          REG_TARGET_BASE: tb_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    dig_q      <= dig_d;
    work_q     <= work_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;
  assign overflowed_o = out_ovf_q;

endmodule

// ===== sv/rsc_checker.sv =====
module rsc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [rsc_pkg::CHAR_W-1:0]     char_code_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [rsc_pkg::OUT_W-1:0]      digit_char_o,
  input logic                           last_digit_o,
  input logic                           overflowed_o
);

  import rsc_pkg::*;

  // stalled digit holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_char_o)
      && $stable(last_digit_o) && $stable(overflowed_o))
    else $error("stalled digit changed");

  // only ascii 0-9 or A-Z come out
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= OUT_W'(48) && digit_char_o <= OUT_W'(57))
      || (digit_char_o >= OUT_W'(65) && digit_char_o <= OUT_W'(90)))
    else $error("digit character out of range");

  // no new character while a number is still being emitted
  a_no_take_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_digit_o |-> in_stall_o)
    else $error("input taken during emission");

  // newline starts the conversion
  a_nl_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && char_code_i == CHAR_NEWLINE |=> in_stall_o)
    else $error("input not stalled after newline");

endmodule

bind radix_string_converter_unit rsc_checker u_rsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .char_code_i  (char_code_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o),
  .overflowed_o (overflowed_o)
);
